// ===== rtl/cdll_pkg.sv =====
// Shared types and codes for the circular doubly linked list engine.
package cdll_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned OP_W  = 3;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned OCC_W = 5;

  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_LIST_FWD = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST_REV = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
    logic [OCC_W-1:0]        occupancy;
  } rsp_t;

  // Source of the node store read address.
  typedef enum logic [1:0] {
    RA_HEAD,
    RA_NEXT,
    RA_PREV
  } ra_e;

  typedef struct packed {
    logic            capture;
    ra_e             ra_sel;
    logic            ins_first;
    logic            ins_node;
    logic            ins_link;
    logic            at_head;
    logic            scan_step;
    logic            rm_capture;
    logic            rm_unlink;
    logic            list_step;
    logic            clear;
    logic            emit;
    logic [ST_W-1:0] emit_status;
    logic            emit_value;
    logic            emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic last_step;
  } dp_stat_t;

endpackage

// ===== rtl/cdll_ctrl.sv =====
// Sequencer for the list engine: decodes each word and steps the datapath.
module cdll_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic [cdll_pkg::OP_W-1:0]      op_i,
  input  cdll_pkg::dp_stat_t             stat_i,
  output cdll_pkg::dp_cmd_t              cmd_o,
  output logic                           busy_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_FIRST,
    S_INS_NODE,
    S_INS_LINK,
    S_RM_SCAN,
    S_RM_UNLINK,
    S_LIST_FWD,
    S_LIST_PRE,
    S_LIST_REV,
    S_CLEAR,
    S_RESP
  } state_e;

  state_e                      state_q, state_d;
  logic [cdll_pkg::ST_W-1:0]   st_q, st_d;
  logic                        at_head_q, at_head_d;
  logic                        busy_q;

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    at_head_d   = at_head_q;
    cmd_o       = '0;
    cmd_o.ra_sel = cdll_pkg::RA_HEAD;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          case (op_i)
            cdll_pkg::OP_INS_HEAD, cdll_pkg::OP_INS_TAIL: begin
              at_head_d = (op_i == cdll_pkg::OP_INS_HEAD);
              if (stat_i.full) begin
                st_d    = cdll_pkg::ST_FULL;
                state_d = S_RESP;
              end else if (stat_i.empty) begin
                state_d = S_INS_FIRST;
              end else begin
                state_d = S_INS_NODE;
              end
            end
            cdll_pkg::OP_REMOVE: begin
              if (stat_i.empty) begin
                st_d    = cdll_pkg::ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_RM_SCAN;
              end
            end
            cdll_pkg::OP_LIST_FWD: begin
              if (stat_i.empty) begin
                st_d    = cdll_pkg::ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_LIST_FWD;
              end
            end
            cdll_pkg::OP_LIST_REV: begin
              if (stat_i.empty) begin
                st_d    = cdll_pkg::ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_LIST_PRE;
              end
            end
            cdll_pkg::OP_CLEAR: begin
              state_d = S_CLEAR;
            end
            default: begin
              st_d    = cdll_pkg::ST_OK;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_INS_FIRST: begin
        cmd_o.ins_first   = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = cdll_pkg::ST_OK;
        cmd_o.emit_last   = 1'b1;
        state_d           = S_IDLE;
      end
      S_INS_NODE: begin
        cmd_o.ins_node = 1'b1;
        state_d        = S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd_o.ins_link    = 1'b1;
        cmd_o.at_head     = at_head_q;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = cdll_pkg::ST_OK;
        cmd_o.emit_last   = 1'b1;
        state_d           = S_IDLE;
      end
      S_RM_SCAN: begin
        if (stat_i.match) begin
          cmd_o.rm_capture = 1'b1;
          state_d          = S_RM_UNLINK;
        end else if (stat_i.last_step) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = cdll_pkg::ST_NOT_FOUND;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
          cmd_o.ra_sel    = cdll_pkg::RA_NEXT;
        end
      end
      S_RM_UNLINK: begin
        cmd_o.rm_unlink   = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = cdll_pkg::ST_OK;
        cmd_o.emit_last   = 1'b1;
        state_d           = S_IDLE;
      end
      S_LIST_PRE: begin
        // hop from the head to the tail before the reverse walk
        cmd_o.ra_sel = cdll_pkg::RA_PREV;
        state_d      = S_LIST_REV;
      end
      S_LIST_FWD, S_LIST_REV: begin
        cmd_o.ra_sel      = (state_q == S_LIST_FWD) ? cdll_pkg::RA_NEXT : cdll_pkg::RA_PREV;
        cmd_o.list_step   = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = cdll_pkg::ST_OK;
        cmd_o.emit_value  = 1'b1;
        cmd_o.emit_last   = stat_i.last_step;
        if (stat_i.last_step) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.clear       = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = cdll_pkg::ST_OK;
        cmd_o.emit_last   = 1'b1;
        state_d           = S_IDLE;
      end
      S_RESP: begin
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = st_q;
        cmd_o.emit_last   = 1'b1;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      st_q      <= cdll_pkg::ST_OK;
      at_head_q <= 1'b0;
      busy_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      st_q      <= st_d;
      at_head_q <= at_head_d;
      busy_q    <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

// ===== rtl/cdll_dp.sv =====
// Datapath of the list engine: node stores, head, count, occupancy map and result register.
module cdll_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [cdll_pkg::VAL_W-1:0]   item_value_i,
  input  cdll_pkg::dp_cmd_t                   cmd_i,
  output cdll_pkg::dp_stat_t                  stat_o,
  output logic                                res_strobe_o,
  output cdll_pkg::rsp_t                      res_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // node stores, one read and one write address per cycle each
  logic [cdll_pkg::VAL_W-1:0] val_mem  [CAPACITY];
  logic [IDX_W-1:0]           next_mem [CAPACITY];
  logic [IDX_W-1:0]           prev_mem [CAPACITY];

  logic [cdll_pkg::VAL_W-1:0] val_rd_q;
  logic [IDX_W-1:0]           next_rd_q, prev_rd_q;

  logic [CAPACITY-1:0]        used_q, used_d;
  logic [IDX_W-1:0]           head_q, head_d;
  logic [CNT_W-1:0]           count_q, count_d;

  logic signed [cdll_pkg::VAL_W-1:0] operand_q;
  logic [IDX_W-1:0]           cur_q, k_q, tail_q, nx_q, pv_q;

  logic [IDX_W-1:0]           rd_addr;
  logic [IDX_W-1:0]           alloc;

  logic                       val_we;
  logic                       next_we, prev_we;
  logic [IDX_W-1:0]           next_wa, next_wd, prev_wa, prev_wd;

  logic                       res_valid_q;
  cdll_pkg::rsp_t             res_q;

  // lowest free node
  always_comb begin
    alloc = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        alloc = IDX_W'(i);
      end
    end
  end

  always_comb begin
    case (cmd_i.ra_sel)
      cdll_pkg::RA_NEXT: rd_addr = next_rd_q;
      cdll_pkg::RA_PREV: rd_addr = prev_rd_q;
      default:           rd_addr = head_q;
    endcase
  end

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CNT_W'(CAPACITY));
  assign stat_o.match     = (val_rd_q == operand_q);
  assign stat_o.last_step = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);

  // link writes
  assign val_we = cmd_i.ins_first | cmd_i.ins_node;

  always_comb begin
    next_we = 1'b0;
    prev_we = 1'b0;
    next_wa = alloc;
    next_wd = alloc;
    prev_wa = alloc;
    prev_wd = alloc;
    if (cmd_i.ins_first) begin
      next_we = 1'b1;
      prev_we = 1'b1;
    end else if (cmd_i.ins_node) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      next_wd = head_q;
      prev_wd = prev_rd_q;
    end else if (cmd_i.ins_link) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      next_wa = tail_q;
      prev_wa = head_q;
    end else if (cmd_i.rm_unlink && (count_q != CNT_W'(1))) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      next_wa = pv_q;
      next_wd = nx_q;
      prev_wa = nx_q;
      prev_wd = pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[alloc] <= operand_q;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    val_rd_q  <= val_mem[rd_addr];
    next_rd_q <= next_mem[rd_addr];
    prev_rd_q <= prev_mem[rd_addr];
  end

  // list bookkeeping
  always_comb begin
    used_d  = used_q;
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.ins_first || cmd_i.ins_link) begin
      used_d[alloc] = 1'b1;
      count_d       = count_q + CNT_W'(1);
      if (cmd_i.ins_first || cmd_i.at_head) begin
        head_d = alloc;
      end
    end
    if (cmd_i.rm_unlink) begin
      used_d[cur_q] = 1'b0;
      count_d       = count_q - CNT_W'(1);
      if (count_q == CNT_W'(1)) begin
        head_d = '0;
      end else if (cur_q == head_q) begin
        head_d = nx_q;
      end
    end
    if (cmd_i.clear) begin
      used_d  = '0;
      head_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      head_q      <= head_d;
      count_q     <= count_d;
      res_valid_q <= cmd_i.emit;
    end
  end

  // walk registers and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      operand_q <= item_value_i;
      cur_q     <= head_q;
      k_q       <= '0;
    end
    if (cmd_i.scan_step) begin
      cur_q <= next_rd_q;
      k_q   <= k_q + IDX_W'(1);
    end
    if (cmd_i.list_step) begin
      k_q <= k_q + IDX_W'(1);
    end
    if (cmd_i.ins_node) begin
      tail_q <= prev_rd_q;
    end
    if (cmd_i.rm_capture) begin
      nx_q <= next_rd_q;
      pv_q <= prev_rd_q;
    end
    if (cmd_i.emit) begin
      res_q.status    <= cmd_i.emit_status;
      res_q.out_value <= cmd_i.emit_value ? val_rd_q : '0;
      res_q.last      <= cmd_i.emit_last;
      res_q.occupancy <= cdll_pkg::OCC_W'(count_d);
    end
  end

  assign res_strobe_o = res_valid_q;
  assign res_o        = res_q;

endmodule

// ===== rtl/circular_doubly_linked_list_engine_unit.sv =====
// Top level of the circular doubly linked list engine.
//
// Usage: drive a command word on req_i (op, item_value) and raise start; the
// word is taken at a rising edge where start is high and busy is low. Each
// result word appears on res_o for one cycle with res_strobe_o high, and the
// receiver must take it then: there is no back-pressure on results. The last
// result of a command has last set; busy drops in the same cycle that word
// shows, so the next command may be issued right then.
//
// An insert writes the node and then links it in, both together for an
// empty list; full, empty and unknown-op answers come from a response
// state and clear from its own; remove walks from the head to a match or
// the list end; listing gives one result word per cycle, reverse from the tail.
// The walk rate of one node per cycle is set by the single registered read
// port of the node stores, whose next read address is the link just read.
//
// Reset (rst_ni low, asynchronous) empties the list: occupancy map, head and
// count clear at once; node stores are left as they are and are only read
// once written. No clearing pass is needed.
module circular_doubly_linked_list_engine_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cdll_pkg::req_t    req_i,
  output logic              res_strobe_o,
  output cdll_pkg::rsp_t    res_o
);

  cdll_pkg::dp_cmd_t  cmd;
  cdll_pkg::dp_stat_t stat;

  // sequencer: decode the command word and drive the walk
  cdll_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (req_i.op),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // node stores, link updates and the result register
  cdll_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_value_i (req_i.item_value),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

// ===== rtl/cdll_chk.sv =====
// Port-level checker for the list engine, bound to the top level.
module cdll_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input cdll_pkg::rsp_t res_o,
  input logic           res_strobe_o
);

  // every accepted word sets busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("engine not busy after accepting a word");

  // a non-final result only shows while the command is still running
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.last |-> busy)
    else $error("intermediate result while idle");

  // the final result frees the engine
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.last |-> !busy)
    else $error("busy with final result showing");

  // busy only drops together with a final result
  a_fall_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_strobe_o && res_o.last)
    else $error("busy dropped without final result");

  // error statuses are single final words with zero value
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && (res_o.status != cdll_pkg::ST_OK)
      |-> res_o.last && (res_o.out_value == '0))
    else $error("malformed error result");

endmodule

bind circular_doubly_linked_list_engine_unit cdll_chk u_cdll_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_o        (res_o),
  .res_strobe_o (res_strobe_o)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the circular doubly linked list engine.
module tb;

  localparam int CAPACITY       = 16;
  localparam int IDLE_PCT       = 26;
  localparam int RANDOM_WORDS   = 436;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 1000;

  // Spare op codes: the block answers with a plain ok and changes nothing.
  localparam logic [cdll_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [cdll_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  cdll_pkg::req_t   req_i;
  logic             res_strobe_o;
  cdll_pkg::rsp_t   res_o;

  // Predicted list state.
  logic signed [cdll_pkg::VAL_W-1:0] ml_value [CAPACITY];
  logic [3:0]                        ml_next  [CAPACITY];
  logic [3:0]                        ml_prev  [CAPACITY];
  logic [CAPACITY-1:0]               ml_used;
  logic [3:0]                        ml_head;
  logic [cdll_pkg::OCC_W-1:0]        ml_count;

  cdll_pkg::rsp_t due_words[$];
  cdll_pkg::rsp_t got_word;
  cdll_pkg::rsp_t want_word;
  int   mismatches;
  int   quiet_cycles;
  bit   idle_on;

  circular_doubly_linked_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic push_word(input logic [cdll_pkg::ST_W-1:0] st,
                           input logic signed [cdll_pkg::VAL_W-1:0] v,
                           input logic lst);
    cdll_pkg::rsp_t r;
    r.status    = st;
    r.out_value = v;
    r.last      = lst;
    r.occupancy = ml_count;
    due_words.push_back(r);
  endtask

  // Advance the predicted list by one command word and queue its results.
  task automatic model_list_op(input cdll_pkg::req_t w);
    logic [cdll_pkg::ST_W-1:0] st;
    logic [3:0]      n;
    logic [3:0]      tail;
    logic [3:0]      cur;
    logic [3:0]      nx;
    logic [3:0]      pv;
    bit              found;
    int              k;
    st = cdll_pkg::ST_OK;
    case (w.op)
      cdll_pkg::OP_INS_HEAD, cdll_pkg::OP_INS_TAIL: begin
        if (ml_count >= CAPACITY) begin
          st = cdll_pkg::ST_FULL;
        end else begin
          n = '0;
          for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!ml_used[i]) n = 4'(i);
          end
          ml_used[n]  = 1'b1;
          ml_value[n] = w.item_value;
          if (ml_count == 0) begin
            ml_next[n] = n;
            ml_prev[n] = n;
            ml_head    = n;
          end else begin
            tail             = ml_prev[ml_head];
            ml_next[n]       = ml_head;
            ml_prev[n]       = tail;
            ml_next[tail]    = n;
            ml_prev[ml_head] = n;
            if (w.op == cdll_pkg::OP_INS_HEAD) ml_head = n;
          end
          ml_count = ml_count + cdll_pkg::OCC_W'(1);
        end
      end
      cdll_pkg::OP_REMOVE: begin
        if (ml_count == 0) begin
          st = cdll_pkg::ST_EMPTY;
        end else begin
          found = 1'b0;
          cur   = ml_head;
          for (k = 0; k < ml_count && !found; k++) begin
            if (ml_value[cur] == w.item_value) begin
              found       = 1'b1;
              ml_used[cur] = 1'b0;
              ml_count    = ml_count - cdll_pkg::OCC_W'(1);
              if (ml_count == 0) begin
                ml_head = '0;
              end else begin
                nx          = ml_next[cur];
                pv          = ml_prev[cur];
                ml_next[pv] = nx;
                ml_prev[nx] = pv;
                if (cur == ml_head) ml_head = nx;
              end
            end else begin
              cur = ml_next[cur];
            end
          end
          if (!found) st = cdll_pkg::ST_NOT_FOUND;
        end
      end
      cdll_pkg::OP_LIST_FWD, cdll_pkg::OP_LIST_REV: begin
        if (ml_count == 0) begin
          st = cdll_pkg::ST_EMPTY;
        end else begin
          cur = (w.op == cdll_pkg::OP_LIST_REV) ? ml_prev[ml_head] : ml_head;
          for (k = 0; k < ml_count; k++) begin
            push_word(cdll_pkg::ST_OK, ml_value[cur], k + 1 == ml_count);
            cur = (w.op == cdll_pkg::OP_LIST_REV) ? ml_prev[cur] : ml_next[cur];
          end
          return;
        end
      end
      cdll_pkg::OP_CLEAR: begin
        ml_used  = '0;
        ml_head  = '0;
        ml_count = '0;
      end
      default: ;
    endcase
    push_word(st, '0, 1'b1);
  endtask

  // Hand one command word to the block; predict it once busy is seen low.
  task automatic issue_word(input logic [cdll_pkg::OP_W-1:0] op,
                            input logic signed [cdll_pkg::VAL_W-1:0] value);
    cdll_pkg::req_t w;
    w.op         = op;
    w.item_value = value;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    model_list_op(w);
  endtask

  function automatic logic signed [cdll_pkg::VAL_W-1:0] stored_value_at(
      input int unsigned steps);
    logic [3:0] cur;
    cur = ml_head;
    repeat (steps) cur = ml_next[cur];
    return ml_value[cur];
  endfunction

  // Small pool with repeats so removes hit and duplicates occur; extremes now and then.
  function automatic logic signed [cdll_pkg::VAL_W-1:0] pool_value();
    int pick;
    pick = $urandom_range(0, 11);
    if (pick == 10) return 32'sh8000_0000;
    if (pick == 11) return 32'sh7fff_ffff;
    return pick - 4;
  endfunction

  task automatic test_empty_list();
    issue_word(cdll_pkg::OP_REMOVE, 32'sd0);
    issue_word(cdll_pkg::OP_LIST_FWD, $urandom());
    issue_word(cdll_pkg::OP_LIST_REV, $urandom());
    issue_word(OP_RSVD6, $urandom());
    issue_word(OP_RSVD7, $urandom());
    issue_word(cdll_pkg::OP_CLEAR, $urandom());
    // Insert at the tail of an empty list, then take the only node away.
    issue_word(cdll_pkg::OP_INS_TAIL, 32'sd42);
    issue_word(cdll_pkg::OP_REMOVE, 32'sd42);
    issue_word(cdll_pkg::OP_INS_HEAD, 32'sd7);
  endtask

  task automatic test_full_store();
    int i;
    issue_word(cdll_pkg::OP_INS_HEAD, 32'sh8000_0000);
    issue_word(cdll_pkg::OP_INS_TAIL, 32'sh7fff_ffff);
    for (i = 0; ml_count < CAPACITY; i++) begin
      issue_word((i % 3 == 0) ? cdll_pkg::OP_INS_HEAD : cdll_pkg::OP_INS_TAIL,
                 (i % 4) - 1);
    end
    issue_word(cdll_pkg::OP_INS_HEAD, 32'sd99);
    issue_word(cdll_pkg::OP_INS_TAIL, 32'sd99);
    issue_word(cdll_pkg::OP_LIST_FWD, '0);
    issue_word(cdll_pkg::OP_LIST_REV, '0);
    // Drop the head, a repeated value, the first node with the tail's value, and one that is absent.
    issue_word(cdll_pkg::OP_REMOVE, stored_value_at(0));
    issue_word(cdll_pkg::OP_REMOVE, -32'sd1);
    issue_word(cdll_pkg::OP_REMOVE, stored_value_at(ml_count - 1));
    issue_word(cdll_pkg::OP_REMOVE, 32'sh5a5a_5a5a);
    issue_word(cdll_pkg::OP_CLEAR, '0);
  endtask

  task automatic test_random_traffic();
    int                                i;
    int                                roll;
    int                                grow_pct;
    logic [cdll_pkg::OP_W-1:0]         op;
    logic signed [cdll_pkg::VAL_W-1:0] v;
    grow_pct = 50;
    for (i = 0; i < RANDOM_WORDS; i++) begin
      // Swing between growing and shrinking so the list visits empty and full.
      if (i % 40 == 0) grow_pct = $urandom_range(15, 85);
      idle_on = !(i >= 150 && i < 270);
      roll = $urandom_range(0, 99);
      v    = $urandom_range(0, 1) ? pool_value() : $urandom();
      if (roll < 72) begin
        if ($urandom_range(0, 99) < grow_pct) begin
          op = $urandom_range(0, 1) ? cdll_pkg::OP_INS_HEAD : cdll_pkg::OP_INS_TAIL;
        end else begin
          op = cdll_pkg::OP_REMOVE;
          if (ml_count != 0 && $urandom_range(0, 99) < 85)
            v = stored_value_at($urandom_range(0, ml_count - 1));
        end
      end else if (roll < 88) begin
        op = $urandom_range(0, 1) ? cdll_pkg::OP_LIST_FWD : cdll_pkg::OP_LIST_REV;
      end else if (roll < 90) begin
        op = cdll_pkg::OP_CLEAR;
      end else if (roll < 92) begin
        op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
      end else begin
        op = cdll_pkg::OP_REMOVE;
      end
      issue_word(op, v);
    end
    idle_on = 1'b1;
  endtask

  // Compare every result word with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o === 1'b1) begin
      got_word = res_o;
      if (due_words.size() == 0) begin
        $error("result word with none due: status %0d value %0d last %0d occupancy %0d",
               got_word.status, got_word.out_value, got_word.last, got_word.occupancy);
        mismatches++;
      end else begin
        want_word = due_words.pop_front();
        if (got_word.status !== want_word.status) begin
          $error("status: expected %0d, got %0d", want_word.status, got_word.status);
          mismatches++;
        end
        if (got_word.out_value !== want_word.out_value) begin
          $error("out_value: expected %0d, got %0d", want_word.out_value, got_word.out_value);
          mismatches++;
        end
        if (got_word.last !== want_word.last) begin
          $error("last: expected %0d, got %0d", want_word.last, got_word.last);
          mismatches++;
        end
        if (got_word.occupancy !== want_word.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want_word.occupancy, got_word.occupancy);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run: count cycles in which no word moves either way.
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || res_strobe_o === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    req_i        <= '0;
    mismatches   = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    ml_used      = '0;
    ml_head      = '0;
    ml_count     = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_full_store();
    test_random_traffic();

    start <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cdll_pkg.sv
rtl/cdll_ctrl.sv
rtl/cdll_dp.sv
rtl/circular_doubly_linked_list_engine_unit.sv
rtl/cdll_chk.sv
sim/tb.sv
